>>> sv/tcs_pkg.sv
// Shared types, constants and register codes of the trilinear sampler.
package tcs_pkg;

	localparam int MAX_INTERIOR = 30;
	localparam int VALUE_BITS   = 32;
	localparam int FRAC_BITS    = 16;
	localparam int POS_BITS     = 32;
	localparam int IDX_BITS     = 5;
	localparam int BANK_AW      = 3 * (IDX_BITS - 1);
	localparam int BANK_DEPTH   = 1 << BANK_AW;
	localparam int NUM_BANKS    = 8;

	localparam logic [FRAC_BITS-1:0] ONE_HALF = FRAC_BITS'(1) << (FRAC_BITS - 1);

	// Item kinds on the request channel.
	typedef enum logic {
		ACT_WRITE  = 1'b0,
		ACT_SAMPLE = 1'b1
	} action_t;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_GRID_NX    = 3'd0,
		REG_GRID_NY    = 3'd1,
		REG_GRID_NZ    = 3'd2,
		REG_INV_CELL_X = 3'd3,
		REG_INV_CELL_Y = 3'd4,
		REG_INV_CELL_Z = 3'd5,
		REG_SPARE6     = 3'd6,
		REG_SPARE7     = 3'd7
	} cfg_reg_t;

	// Index pair and weight along one axis.
	typedef struct packed {
		logic [IDX_BITS-1:0]  i0;
		logic [IDX_BITS-1:0]  i1;
		logic [FRAC_BITS-1:0] w;
	} axis_t;

endpackage

>>> sv/tcs_ifaces.sv
// Channel interfaces: request stream, result stream and configuration writes.
interface tcs_req_if;
	import tcs_pkg::*;
	logic                         valid;
	logic                         ready;
	logic                         action;
	logic [IDX_BITS-1:0]          cell_i;
	logic [IDX_BITS-1:0]          cell_j;
	logic [IDX_BITS-1:0]          cell_k;
	logic signed [VALUE_BITS-1:0] cell_value;
	logic [POS_BITS-1:0]          pos_x;
	logic [POS_BITS-1:0]          pos_y;
	logic [POS_BITS-1:0]          pos_z;
	modport source (output valid, action, cell_i, cell_j, cell_k, cell_value,
		pos_x, pos_y, pos_z, input ready);
	modport sink (input valid, action, cell_i, cell_j, cell_k, cell_value,
		pos_x, pos_y, pos_z, output ready);
endinterface

interface tcs_rsp_if;
	import tcs_pkg::*;
	logic                         valid;
	logic                         ready;
	logic signed [VALUE_BITS-1:0] sample_value;
	modport source (output valid, sample_value, input ready);
	modport sink (input valid, sample_value, output ready);
endinterface

interface tcs_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> sv/tcs_ram.sv
// Generic simple dual-port RAM with registered read.
module tcs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

>>> sv/tcs_axis.sv
// Per-axis scaling, saturation and split into index pair and weight.
module tcs_axis (
	input  logic                           clk,
	input  logic                           en,
	input  logic [tcs_pkg::POS_BITS-1:0]   pos,
	input  logic [31:0]                    inv,
	input  logic [tcs_pkg::IDX_BITS-1:0]   n,
	output tcs_pkg::axis_t                 res_s2
);
	import tcs_pkg::*;

	localparam int PROD_BITS   = POS_BITS + 32;
	localparam int SCALED_BITS = PROD_BITS - FRAC_BITS;
	localparam int F_BITS      = IDX_BITS + FRAC_BITS + 1;

	logic [PROD_BITS-1:0]   prod_s1;
	logic [IDX_BITS-1:0]    n_eff;
	logic [SCALED_BITS-1:0] scaled;
	logic [SCALED_BITS-1:0] lim;
	logic [SCALED_BITS-1:0] sat;
	logic [F_BITS-1:0]      f;
	logic [IDX_BITS:0]      lo;
	logic [IDX_BITS:0]      hi;
	logic [IDX_BITS:0]      top;
	axis_t                  res;

	// First stage: the position times the reciprocal cell size.
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= PROD_BITS'(pos) * PROD_BITS'(inv);
		end
	end

	// Second stage: saturate, add one half, split into floor and fraction.
	always_comb begin
		n_eff  = (n > IDX_BITS'(MAX_INTERIOR)) ? IDX_BITS'(MAX_INTERIOR) : n;
		scaled = prod_s1[PROD_BITS-1:FRAC_BITS];
		lim    = SCALED_BITS'(n_eff) << FRAC_BITS;
		sat    = (scaled > lim) ? lim : scaled;
		f      = F_BITS'(sat) + F_BITS'(ONE_HALF);
		top    = (IDX_BITS+1)'(n_eff) + 1'b1;
		lo     = f[F_BITS-1:FRAC_BITS];
		if (lo > top) begin
			lo = top;
		end
		hi     = (lo + 1'b1 > top) ? top : lo + 1'b1;
		res.i0 = lo[IDX_BITS-1:0];
		res.i1 = hi[IDX_BITS-1:0];
		res.w  = (hi == lo) ? '0 : f[FRAC_BITS-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s2 <= res;
		end
	end
endmodule

>>> sv/tcs_blend.sv
// One registered linear blend: a + floor((b - a) * w / 2^FRAC_BITS).
module tcs_blend (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [tcs_pkg::VALUE_BITS-1:0] a,
	input  logic signed [tcs_pkg::VALUE_BITS-1:0] b,
	input  logic [tcs_pkg::FRAC_BITS-1:0]       w,
	output logic signed [tcs_pkg::VALUE_BITS-1:0] y_q
);
	import tcs_pkg::*;

	localparam int DIFF_BITS = VALUE_BITS + 1;
	localparam int MUL_BITS  = DIFF_BITS + FRAC_BITS + 1;
	localparam int SH_BITS   = MUL_BITS - FRAC_BITS;

	logic signed [DIFF_BITS-1:0] diff;
	logic signed [FRAC_BITS:0]   ws;
	logic signed [MUL_BITS-1:0]  prod;
	logic signed [SH_BITS-1:0]   sum;

	// The arithmetic shift of the product rounds toward minus infinity.
	always_comb begin
		diff = DIFF_BITS'(b) - DIFF_BITS'(a);
		ws   = $signed({1'b0, w});
		prod = MUL_BITS'(diff) * MUL_BITS'(ws);
		sum  = SH_BITS'(a) + prod[MUL_BITS-1:FRAC_BITS];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			y_q <= sum[VALUE_BITS-1:0];
		end
	end
endmodule

>>> sv/cell_centered_trilinear_sampler.sv
// Pipeline from request to result: scale, split, read, then x, y and z blend registers.
// Throughput: one request per cycle while no result is stalled; the single 32 by 32
// multiply per axis and eight parity banks, each with one read port, sustain that rate.
// A stalled result holds the whole pipeline; nothing is lost or repeated.
// Reset clears the valid bits and sets the registers to 30 cells and unit reciprocals;
// the cell store is not cleared and holds nothing defined until written.
module cell_centered_trilinear_sampler (
	input  logic       clk,
	input  logic       arst_n,
	tcs_req_if.sink    req,
	tcs_rsp_if.source  rsp,
	tcs_cfg_if.sink    cfg
);
	import tcs_pkg::*;

	logic [IDX_BITS-1:0] grid_nx_q, grid_ny_q, grid_nz_q;
	logic [31:0]         inv_cell_x_q, inv_cell_y_q, inv_cell_z_q;
	logic                en;

	logic                         v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic                         act_s1, act_s2;
	logic [IDX_BITS-1:0]          ci_s1, cj_s1, ck_s1, ci_s2, cj_s2, ck_s2;
	logic signed [VALUE_BITS-1:0] val_s1, val_s2;
	axis_t                        ax_s2, ay_s2, az_s2;
	logic [FRAC_BITS-1:0]         wi_s3, wj_s3, wk_s3, wj_s4, wk_s4, wk_s5;
	logic [2:0]                   par_s3;

	logic [VALUE_BITS-1:0]        rd [NUM_BANKS];
	logic signed [VALUE_BITS-1:0] cx [4];
	logic signed [VALUE_BITS-1:0] cy [2];

	// The pipeline advances unless a result waits on a stalled sink.
	assign en        = !v_s6 || rsp.ready;
	assign req.ready = en;
	assign cfg.ready = 1'b1;
	assign rsp.valid = v_s6;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_nx_q    <= IDX_BITS'(30);
			grid_ny_q    <= IDX_BITS'(30);
			grid_nz_q    <= IDX_BITS'(30);
			inv_cell_x_q <= 32'd65536;
			inv_cell_y_q <= 32'd65536;
			inv_cell_z_q <= 32'd65536;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_GRID_NX:    grid_nx_q    <= cfg.data[IDX_BITS-1:0];
				REG_GRID_NY:    grid_ny_q    <= cfg.data[IDX_BITS-1:0];
				REG_GRID_NZ:    grid_nz_q    <= cfg.data[IDX_BITS-1:0];
				REG_INV_CELL_X: inv_cell_x_q <= cfg.data;
				REG_INV_CELL_Y: inv_cell_y_q <= cfg.data;
				REG_INV_CELL_Z: inv_cell_z_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Valid bits; a write item drops out of the pipeline after the store stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= req.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2 && (act_s2 == ACT_SAMPLE);
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// Payload carried alongside the axis math.
	always_ff @(posedge clk) begin
		if (en) begin
			act_s1 <= req.action;
			ci_s1  <= req.cell_i;
			cj_s1  <= req.cell_j;
			ck_s1  <= req.cell_k;
			val_s1 <= req.cell_value;
			act_s2 <= act_s1;
			ci_s2  <= ci_s1;
			cj_s2  <= cj_s1;
			ck_s2  <= ck_s1;
			val_s2 <= val_s1;
			wi_s3  <= ax_s2.w;
			wj_s3  <= ay_s2.w;
			wk_s3  <= az_s2.w;
			par_s3 <= {az_s2.i0[0], ay_s2.i0[0], ax_s2.i0[0]};
			wj_s4  <= wj_s3;
			wk_s4  <= wk_s3;
			wk_s5  <= wk_s4;
		end
	end

	tcs_axis u_axis_x (.clk, .en, .pos(req.pos_x), .inv(inv_cell_x_q), .n(grid_nx_q),
		.res_s2(ax_s2));
	tcs_axis u_axis_y (.clk, .en, .pos(req.pos_y), .inv(inv_cell_y_q), .n(grid_ny_q),
		.res_s2(ay_s2));
	tcs_axis u_axis_z (.clk, .en, .pos(req.pos_z), .inv(inv_cell_z_q), .n(grid_nz_q),
		.res_s2(az_s2));

	// Eight banks split by index parity; neighbors along an axis sit in opposite banks.
	for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
		localparam logic [2:0] BID = 3'(b);
		logic [IDX_BITS-1:0] isel, jsel, ksel;
		logic [BANK_AW-1:0]  raddr;
		logic                we;

		always_comb begin
			isel  = (ax_s2.i0[0] == BID[0]) ? ax_s2.i0 : ax_s2.i1;
			jsel  = (ay_s2.i0[0] == BID[1]) ? ay_s2.i0 : ay_s2.i1;
			ksel  = (az_s2.i0[0] == BID[2]) ? az_s2.i0 : az_s2.i1;
			raddr = {ksel[IDX_BITS-1:1], jsel[IDX_BITS-1:1], isel[IDX_BITS-1:1]};
			we    = en && v_s2 && (act_s2 == ACT_WRITE) &&
				({ck_s2[0], cj_s2[0], ci_s2[0]} == BID);
		end

		tcs_ram #(.WIDTH(VALUE_BITS), .DEPTH(BANK_DEPTH)) u_ram (
			.clk,
			.we,
			.waddr({ck_s2[IDX_BITS-1:1], cj_s2[IDX_BITS-1:1], ci_s2[IDX_BITS-1:1]}),
			.wdata(val_s2),
			.re(en),
			.raddr,
			.rdata(rd[b])
		);
	end

	// Blend along x: four corner pairs, each pair from opposite x banks.
	for (genvar g = 0; g < 4; g++) begin : g_bx
		localparam logic [1:0] GID = 2'(g);
		logic [2:0] b0, b1;
		assign b0 = {par_s3[2] ^ GID[1], par_s3[1] ^ GID[0], par_s3[0]};
		assign b1 = {par_s3[2] ^ GID[1], par_s3[1] ^ GID[0], ~par_s3[0]};
		tcs_blend u_bx (.clk, .en, .a($signed(rd[b0])), .b($signed(rd[b1])),
			.w(wi_s3), .y_q(cx[g]));
	end

	// Blend along y, then along z into the output register.
	for (genvar g = 0; g < 2; g++) begin : g_by
		tcs_blend u_by (.clk, .en, .a(cx[2*g]), .b(cx[2*g+1]), .w(wj_s4), .y_q(cy[g]));
	end

	tcs_blend u_bz (.clk, .en, .a(cy[0]), .b(cy[1]), .w(wk_s5), .y_q(rsp.sample_value));
endmodule

>>> sv/tcs_checker.sv
// Port-level checks of the sampler, bound to its top level.
module tcs_port_checks (
	input logic        clk,
	input logic        arst_n,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [31:0] rsp_value
);
	// A result waiting on a stalled sink keeps its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value))
		else $error("result changed while stalled");

	// Requests are refused only while a result is stalled.
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> rsp_valid && !rsp_ready)
		else $error("request refused without a stalled result");

	// A stalled result keeps the request side closed in the next cycle too, unless the sink takes it then.
	a_stall_closes: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> !req_ready || rsp_ready)
		else $error("request side open during a held stall");

	// Nothing leaves the block right after reset.
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !rsp_valid)
		else $error("result present right after reset");
endmodule

bind cell_centered_trilinear_sampler tcs_port_checks u_tcs_port_checks (
	.clk(clk),
	.arst_n(arst_n),
	.req_ready(req.ready),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.rsp_value(rsp.sample_value)
);

>>> verif/tcs_checker.sv
// Result checker for the trilinear sampler: watches every channel, predicts samples, compares.
module tcs_checker (
	input  logic     clk,
	input  logic     arst_n,
	tcs_req_if       req,
	tcs_rsp_if       rsp,
	tcs_cfg_if       cfg,
	output int       fail_count,
	output int       pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import tcs_pkg::*;

	localparam int DIM = MAX_INTERIOR + 2;

	logic signed [VALUE_BITS-1:0] cell_mirror [DIM*DIM*DIM];
	logic [IDX_BITS-1:0] n_x, n_y, n_z;
	logic [31:0] inv_x, inv_y, inv_z;
	logic signed [VALUE_BITS-1:0] expected_samples [$];

	// Index pair and weight along one axis.
	function automatic axis_t split_axis(logic [31:0] pos, logic [31:0] inv,
		logic [IDX_BITS-1:0] n_reg);
		logic [63:0] scaled;
		logic [63:0] f;
		logic [63:0] lo, hi, n;
		axis_t a;
		n = (n_reg > MAX_INTERIOR) ? 64'(MAX_INTERIOR) : 64'(n_reg);
		scaled = (64'(pos) * 64'(inv)) >> FRAC_BITS;
		if (scaled > (n << FRAC_BITS))
			scaled = n << FRAC_BITS;
		f = scaled + 64'(ONE_HALF);
		lo = f >> FRAC_BITS;
		if (lo > n + 1)
			lo = n + 1;
		hi = (lo + 1 > n + 1) ? n + 1 : lo + 1;
		a.i0 = lo[IDX_BITS-1:0];
		a.i1 = hi[IDX_BITS-1:0];
		a.w = (hi == lo) ? '0 : f[FRAC_BITS-1:0];
		return a;
	endfunction

	// Linear blend with floor rounding of the weighted difference.
	function automatic longint lerp(longint a, longint b, logic [FRAC_BITS-1:0] w);
		longint prod;
		prod = (b - a) * longint'({1'b0, w});
		return a + (prod >>> FRAC_BITS);
	endfunction

	function automatic longint cell_at(logic [IDX_BITS-1:0] i, logic [IDX_BITS-1:0] j,
		logic [IDX_BITS-1:0] k);
		return longint'(cell_mirror[int'(i) + DIM*int'(j) + DIM*DIM*int'(k)]);
	endfunction

	function automatic logic signed [31:0] interpolate(logic [31:0] px, logic [31:0] py,
		logic [31:0] pz);
		axis_t ax, ay, az;
		longint c00, c10, c01, c11, c0, c1;
		ax = split_axis(px, inv_x, n_x);
		ay = split_axis(py, inv_y, n_y);
		az = split_axis(pz, inv_z, n_z);
		c00 = lerp(cell_at(ax.i0, ay.i0, az.i0), cell_at(ax.i1, ay.i0, az.i0), ax.w);
		c10 = lerp(cell_at(ax.i0, ay.i1, az.i0), cell_at(ax.i1, ay.i1, az.i0), ax.w);
		c01 = lerp(cell_at(ax.i0, ay.i0, az.i1), cell_at(ax.i1, ay.i0, az.i1), ax.w);
		c11 = lerp(cell_at(ax.i0, ay.i1, az.i1), cell_at(ax.i1, ay.i1, az.i1), ax.w);
		c0 = lerp(c00, c10, ay.w);
		c1 = lerp(c01, c11, ay.w);
		return 32'(lerp(c0, c1, az.w));
	endfunction

	assign pending = expected_samples.size();

	// Track configuration, mirror writes, predict samples and check results.
	always @(posedge clk or negedge arst_n) begin
		logic signed [VALUE_BITS-1:0] want;
		if (!arst_n) begin
			n_x <= IDX_BITS'(30); n_y <= IDX_BITS'(30); n_z <= IDX_BITS'(30);
			inv_x <= 32'd65536; inv_y <= 32'd65536; inv_z <= 32'd65536;
			fail_count <= 0;
			expected_samples.delete();
		end else begin
			if (cfg.valid && cfg.ready) begin
				unique case (cfg_reg_t'(cfg.index))
					REG_GRID_NX: n_x <= cfg.data[IDX_BITS-1:0];
					REG_GRID_NY: n_y <= cfg.data[IDX_BITS-1:0];
					REG_GRID_NZ: n_z <= cfg.data[IDX_BITS-1:0];
					REG_INV_CELL_X: inv_x <= cfg.data;
					REG_INV_CELL_Y: inv_y <= cfg.data;
					REG_INV_CELL_Z: inv_z <= cfg.data;
					default: ;
				endcase
			end
			if (req.valid && req.ready) begin
				if (action_t'(req.action) == ACT_WRITE) begin
					if (req.cell_i < DIM && req.cell_j < DIM && req.cell_k < DIM)
						cell_mirror[int'(req.cell_i) + DIM*int'(req.cell_j)
							+ DIM*DIM*int'(req.cell_k)] = req.cell_value;
				end else begin
					expected_samples.push_back(interpolate(req.pos_x, req.pos_y, req.pos_z));
				end
			end
			if (rsp.valid && rsp.ready) begin
				if (expected_samples.size() == 0) begin
					$display("%0t: unexpected sample_value %0d", $time, rsp.sample_value);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_samples.pop_front();
					if (want !== rsp.sample_value) begin
						$display("%0t: sample_value expected %0d actual %0d", $time, want,
							rsp.sample_value);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

>>> verif/testbench.sv
// Stimulus and verdict for the trilinear sampler.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import tcs_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	int fail_count, pending;
	int send_idle_pct = 21, recv_idle_pct = 85;
	bit hold_off = 0;
	longint cycle_count = 0;
	logic [IDX_BITS-1:0] gnx = 5'd30, gny = 5'd30, gnz = 5'd30;

	tcs_req_if req ();
	tcs_rsp_if rsp ();
	tcs_cfg_if cfg ();

	cell_centered_trilinear_sampler dut (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp),
		.cfg(cfg));
	tcs_checker chk (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp), .cfg(cfg),
		.fail_count(fail_count), .pending(pending));

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 400000) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Result side: random stalls, plus a long hold-off when asked.
	always @(negedge clk) begin
		rsp.ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
	end

	initial begin
		rsp.ready = 0;
		req.valid = 0; req.action = 0; req.cell_i = 0; req.cell_j = 0; req.cell_k = 0;
		req.cell_value = 0; req.pos_x = 0; req.pos_y = 0; req.pos_z = 0;
		cfg.valid = 0; cfg.index = 0; cfg.data = 0;
	end

	// One request transfer; idles at random first. Valid stays up for a following item.
	task automatic send_item(action_t act, logic [4:0] ci, logic [4:0] cj, logic [4:0] ck,
		logic [31:0] v, logic [31:0] px, logic [31:0] py, logic [31:0] pz);
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 0;
			@(negedge clk);
		end
		req.valid <= 1; req.action <= act;
		req.cell_i <= ci; req.cell_j <= cj; req.cell_k <= ck; req.cell_value <= v;
		req.pos_x <= px; req.pos_y <= py; req.pos_z <= pz;
		do @(posedge clk); while (!req.ready);
		@(negedge clk);
	endtask

	task automatic write_cell(int i, int j, int k, logic [31:0] v);
		send_item(ACT_WRITE, 5'(i), 5'(j), 5'(k), v, $urandom, $urandom, $urandom);
	endtask

	task automatic sample_at(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
		send_item(ACT_SAMPLE, 5'($urandom), 5'($urandom), 5'($urandom), $urandom,
			px, py, pz);
	endtask

	// One configuration transfer; valid stays up for a following write.
	task automatic write_reg(cfg_reg_t idx, logic [31:0] d);
		cfg.valid <= 1; cfg.index <= idx; cfg.data <= d;
		do @(posedge clk); while (!cfg.ready);
		@(negedge clk);
	endtask

	task automatic drain();
		req.valid <= 0;
		while (pending != 0) @(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	// Fill the whole used block (ghosts included) so every sample reads written cells.
	task automatic fill_grid(bit extremes);
		logic [31:0] v;
		for (int k = 0; k <= gnz + 1; k++)
			for (int j = 0; j <= gny + 1; j++)
				for (int i = 0; i <= gnx + 1; i++) begin
					v = $urandom;
					if (extremes)
						v = ((i + j + k) % 2) ? 32'h7fffffff : 32'h80000000;
					write_cell(i, j, k, v);
				end
	endtask

	task automatic set_grid(logic [4:0] nx, logic [4:0] ny, logic [4:0] nz,
		logic [31:0] ix, logic [31:0] iy, logic [31:0] iz);
		drain();
		write_reg(REG_GRID_NX, 32'(nx)); write_reg(REG_GRID_NY, 32'(ny));
		write_reg(REG_GRID_NZ, 32'(nz));
		write_reg(REG_INV_CELL_X, ix); write_reg(REG_INV_CELL_Y, iy);
		write_reg(REG_INV_CELL_Z, iz);
		cfg.valid <= 0;
		// Sizes above the limit act as the limit.
		gnx = (nx > 30) ? 5'd30 : nx; gny = (ny > 30) ? 5'd30 : ny;
		gnz = (nz > 30) ? 5'd30 : nz;
	endtask

	function automatic logic [31:0] rand_pos();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $urandom_range(32'h0004_0000);
			2: return {16'($urandom_range(40)),
				16'(($urandom_range(2) == 0) ? 0 : $urandom)};
			default: return 32'hffffffff;
		endcase
	endfunction

	task automatic random_samples(int count);
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(9) == 0)
				write_cell($urandom_range(gnx + 1), $urandom_range(gny + 1),
					$urandom_range(gnz + 1), $urandom);
			else
				sample_at(rand_pos(), rand_pos(), rand_pos());
		end
	endtask

	initial begin
		repeat (9) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed: tiny grid with extreme values, extreme positions and reciprocals.
		set_grid(1, 1, 1, 32'd65536, 32'd65536, 32'd65536);
		fill_grid(1);
		sample_at(0, 0, 0);
		sample_at(32'hffffffff, 32'hffffffff, 32'hffffffff);
		sample_at(32'h0000_8000, 32'h0000_4000, 32'h0000_c000);
		set_grid(0, 0, 0, 32'hffffffff, 0, 1);
		sample_at(32'h1234_5678, 32'hffffffff, 32'hffffffff);
		set_grid(2, 1, 3, 0, 32'hffffffff, 32'h0002_0000);
		fill_grid(0);
		sample_at(32'hffffffff, 32'h0000_ffff, 32'h0001_8000);
		sample_at(32'h0001_0000, 32'h0000_0001, 32'h0000_7fff);
		set_grid(31, 31, 31, 32'd65536, 32'd65536, 32'd65536);
		// Writes at the far ghost corner and edge of the full store.
		write_cell(31, 31, 31, 32'h1234);
		write_cell(0, 31, 5, 32'h1234);
		set_grid(3, 2, 4, 32'h0001_4000, 32'h0000_c000, 32'h0003_0000);
		fill_grid(0);
		random_samples(400);

		// Receiver holds off while requests keep coming, so the input backs up.
		fork
			begin
				hold_off = 1;
				repeat (60) @(negedge clk);
				hold_off = 0;
			end
			random_samples(40);
		join

		send_idle_pct = 85; recv_idle_pct = 21;
		set_grid(30, 30, 30, 32'd65536, 32'd65536, 32'd65536);
		for (int k = 0; k < 4; k++)
			for (int j = 0; j < 4; j++)
				for (int i = 0; i < 4; i++)
					write_cell(i, j, k, $urandom);
		gnx = 5'd2; gny = 5'd2; gnz = 5'd2;
		set_grid(2, 2, 2, 32'h0000_8000, 32'h0002_0000, 32'h0001_0000);
		random_samples(300);

		send_idle_pct = 0; recv_idle_pct = 0;
		set_grid(5, 4, 6, 32'h0001_0000, 32'h0001_8000, 32'h0000_c000);
		fill_grid(0);
		random_samples(300);

		drain();
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
